[src/mlcd_pkg.sv]
// ----------------------------------------------------------------------------
// mlcd_pkg: shared types and constants of the frame deframer
// Word formats of both channels, register map, sync and CRC-32 constants.
// ----------------------------------------------------------------------------
package mlcd_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [7:0]  SYNC_FIRST    = 8'h45;
  localparam logic [7:0]  SYNC_SECOND   = 8'h50;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES      = 32'hFFFF_FFFF;
  localparam logic [16:0] HEADER_BYTES  = 17'd8;
  localparam logic [16:0] TRAILER_BYTES = 17'd4;

  localparam logic [7:0]  VERSION_RESET = 8'd1;
  localparam logic [15:0] MAX_LEN_RESET = 16'd260;

  typedef enum logic {
    REG_EXPECTED_VERSION = 1'b0,
    REG_MAX_PAYLOAD      = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_VERSION = 2'd1,
    STATUS_BAD_CRC     = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       flush;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  msg_type;
    logic [15:0] seq_number;
    logic [15:0] payload_len;
    status_e     frame_status;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  expected_version;
    logic [15:0] max_payload;
  } cfg_t;

  // Reflected CRC-32, one byte, unrolled over its eight bits.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[src/magic_length_crc32_deframer.sv]
// ----------------------------------------------------------------------------
// magic_length_crc32_deframer: sync-hunting, length-prefixed frame parser
// Finds 0x45 0x50, reads the header, forwards payload and checks CRC-32.
// ----------------------------------------------------------------------------
// Usage:
//   Feed received bytes on the input channel (in_valid_i / in_ready_o),
//   one word per byte; a word with flush set returns the parser to hunting.
//   Every input word yields exactly one output word on out_valid_o /
//   out_ready_i: kind none, a payload byte with its index, or a frame end
//   carrying status (bad version before bad CRC before ok).
//   The byte is captured in the input register, and the parser step
//   (header capture, byte-wide CRC-32, trailer compare) runs between that
//   register and the output register. Throughput is one byte per cycle
//   while the receiver does not stall, with one byte-wide CRC update per byte.
//   When the receiver stalls, the output register holds its word and the
//   input register still accepts one more byte; the parser state advances
//   only when a result moves into the output register.
//   Reset clears both registers, puts the parser in hunt and loads the
//   configuration defaults (version 1, max payload 260).
//   Write configuration only while no byte is in flight.
// ----------------------------------------------------------------------------
module magic_length_crc32_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  mlcd_pkg::in_word_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mlcd_pkg::out_word_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mlcd_pkg::ADDR_W-1:0] paddr,
  input  logic [mlcd_pkg::DATA_W-1:0] pwdata,
  output logic [mlcd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import mlcd_pkg::*;

  typedef struct packed {
    logic [16:0] pos;
    logic [16:0] total;
    logic [7:0]  version;
    logic [7:0]  msg_type;
    logic [15:0] sequence_nr;
    logic [15:0] length;
    logic [31:0] crc;
    logic [31:0] trailer;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '{
    pos: '0, total: '0, version: '0, msg_type: '0, sequence_nr: '0,
    length: '0, crc: CRC_ONES, trailer: '0
  };

  cfg_t         cfg;
  logic         s1_valid_q;
  in_word_t     s1_word_q;
  logic         out_valid_q;
  out_word_t    out_word_q;
  out_word_t    result;
  parse_state_t state_q, state_d;
  logic         out_load;
  logic         s1_fire;

  logic [7:0]  b;
  logic [31:0] crc_upd;
  logic [15:0] len_new;
  logic [16:0] pos_inc;

  mlcd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: output register loads when empty or drained this cycle.
  assign out_load   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_load;
  assign in_ready_o = !s1_valid_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_word_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_word_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PARSE_CLEAR;
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  assign b       = s1_word_q.rx_byte;
  assign crc_upd = crc32_byte(state_q.crc, b);
  assign len_new = {b, state_q.length[7:0]};
  assign pos_inc = state_q.pos + 17'd1;

  // One parser step per byte.
  always_comb begin
    state_d = state_q;
    result  = '{kind: KIND_NONE, frame_status: STATUS_OK, default: '0};

    if (s1_word_q.flush) begin
      state_d = PARSE_CLEAR;
    end else if (state_q.pos == 17'd0) begin
      // hunt first sync byte
      if (b == SYNC_FIRST) begin
        state_d.pos = 17'd1;
      end
    end else if (state_q.pos == 17'd1) begin
      // second sync byte; a repeated first sync byte keeps waiting
      if (b == SYNC_SECOND) begin
        state_d.pos     = 17'd2;
        state_d.crc     = CRC_ONES;
        state_d.trailer = '0;
        state_d.total   = '0;
      end else if (b != SYNC_FIRST) begin
        state_d = PARSE_CLEAR;
      end
    end else if (state_q.pos < HEADER_BYTES) begin
      // header bytes: capture field, run CRC
      state_d.crc = crc_upd;
      state_d.pos = pos_inc;
      case (state_q.pos[2:0])
        3'd2:    state_d.version = b;
        3'd3:    state_d.msg_type = b;
        3'd4:    state_d.sequence_nr[7:0] = b;
        3'd5:    state_d.sequence_nr[15:8] = b;
        3'd6:    state_d.length[7:0] = b;
        default: state_d.length[15:8] = b;
      endcase
      if (state_q.pos == HEADER_BYTES - 17'd1) begin
        // drop oversized header silently
        if (len_new > cfg.max_payload) begin
          state_d = PARSE_CLEAR;
        end else begin
          state_d.total = HEADER_BYTES + {1'b0, len_new} + TRAILER_BYTES;
        end
      end
    end else if (state_q.total == 17'd0 || state_q.pos >= state_q.total) begin
      state_d = PARSE_CLEAR;
    end else begin
      if (state_q.pos < HEADER_BYTES + {1'b0, state_q.length}) begin
        state_d.crc         = crc_upd;
        result.kind         = KIND_PAYLOAD;
        result.data_byte    = b;
        result.byte_index   = 16'(state_q.pos - HEADER_BYTES);
        result.msg_type     = state_q.msg_type;
        result.seq_number   = state_q.sequence_nr;
        result.payload_len  = state_q.length;
      end else begin
        // trailer arrives little-endian: shift in from the top
        state_d.trailer = {b, state_q.trailer[31:8]};
      end
      state_d.pos = pos_inc;
      if (pos_inc == state_q.total) begin
        result.kind        = KIND_END;
        result.data_byte   = '0;
        result.byte_index  = '0;
        result.msg_type    = state_q.msg_type;
        result.seq_number  = state_q.sequence_nr;
        result.payload_len = state_q.length;
        if (state_q.version != cfg.expected_version) begin
          result.frame_status = STATUS_BAD_VERSION;
        end else if ((state_d.crc ^ CRC_ONES) != state_d.trailer) begin
          result.frame_status = STATUS_BAD_CRC;
        end else begin
          result.frame_status = STATUS_OK;
        end
        state_d = PARSE_CLEAR;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  // Once the length is known, the position stays inside the frame.
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.total != 17'd0 |-> state_q.pos < state_q.total)
    else $error("frame position ran past frame length");

  // Hunting always starts with a fresh CRC.
  a_crc_fresh_in_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pos == 17'd0 |-> state_q.crc == CRC_ONES)
    else $error("CRC not reset while hunting");

  // Status is only carried by frame-end words.
  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.kind != KIND_END |-> out_word_q.frame_status == STATUS_OK)
    else $error("status set on a non frame-end word");

  // An empty output register never blocks the input.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty output register");

endmodule

[src/mlcd_apb_regs.sv]
// ----------------------------------------------------------------------------
// mlcd_apb_regs: configuration registers of the frame deframer
// APB-style write and read of expected version and maximum payload length.
// ----------------------------------------------------------------------------
module mlcd_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mlcd_pkg::ADDR_W-1:0] paddr,
  input  logic [mlcd_pkg::DATA_W-1:0] pwdata,
  output logic [mlcd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output mlcd_pkg::cfg_t             cfg_o
);
  import mlcd_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_version <= VERSION_RESET;
      cfg_q.max_payload      <= MAX_LEN_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_EXPECTED_VERSION: cfg_q.expected_version <= pwdata[7:0];
        REG_MAX_PAYLOAD:      cfg_q.max_payload      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EXPECTED_VERSION: prdata = {24'd0, cfg_q.expected_version};
      REG_MAX_PAYLOAD:      prdata = {16'd0, cfg_q.max_payload};
      default:              prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
